>>> src/br1024_pkg.sv
// ----------------------------------------------------------------------------
// br1024_pkg
// shared constants and types for the balanced radix-1024 scalar recoder
// ----------------------------------------------------------------------------
package br1024_pkg;

    localparam int WORD_W           = 64;
    localparam int WORDS_PER_SCALAR = 4;
    localparam int SCALAR_BITS      = WORD_W * WORDS_PER_SCALAR;
    localparam int WORD_CNT_W       = 2;
    localparam int MAG_W            = 10;
    localparam int IDX_W            = 5;

    localparam int DEF_DIGIT_BITS   = 10;
    localparam int DEF_NUM_DIGITS   = 26;

    // ed25519 group order, least significant word first
    localparam logic [WORD_W-1:0] GROUP_ORDER [WORDS_PER_SCALAR] = '{
        64'h5812631a5cf5d3ed,
        64'h14def9dea2f79cd6,
        64'h0000000000000000,
        64'h1000000000000000
    };

    // one recoded digit plus the carry into the next position
    typedef struct packed {
        logic             carry;
        logic             negative;
        logic             nonzero;
        logic [MAG_W-1:0] magnitude;
    } rec_digit_t;

endpackage

>>> src/br1024_digit_cell.sv
// ----------------------------------------------------------------------------
// br1024_digit_cell
// turns one raw digit plus incoming carry into a balanced sign-magnitude digit
// ----------------------------------------------------------------------------
module br1024_digit_cell
    import br1024_pkg::*;
#(
    parameter int DIGIT_BITS = DEF_DIGIT_BITS
) (
    input  logic [DIGIT_BITS-1:0] bits,
    input  logic                  carry_in,
    output rec_digit_t            digit
);

    localparam int RAW_W = DIGIT_BITS + 1;
    localparam int EXT_W = (RAW_W > MAG_W) ? RAW_W : MAG_W;
    localparam logic [RAW_W-1:0] RADIX = RAW_W'(1) << DIGIT_BITS;
    localparam logic [RAW_W-1:0] HALF  = RAW_W'(1) << (DIGIT_BITS - 1);

    logic [RAW_W-1:0] raw;
    logic [RAW_W-1:0] mag_full;
    logic [EXT_W-1:0] mag_ext;
    logic             wrap;

    always_comb
    begin
        raw      = {1'b0, bits} + RAW_W'(carry_in);
        wrap     = (raw >= HALF);
        // digits at or above half borrow from the next position
        mag_full = wrap ? (RADIX - raw) : raw;
        mag_ext  = EXT_W'(mag_full);

        digit.carry     = wrap;
        digit.nonzero   = (mag_full != '0);
        digit.negative  = wrap && (mag_full != '0);
        digit.magnitude = mag_ext[MAG_W-1:0];
    end

endmodule

>>> src/balanced_radix1024_scalar_recoder_core.sv
// ----------------------------------------------------------------------------
// balanced_radix1024_scalar_recoder_core
// recodes a 256-bit scalar into balanced radix-2^DIGIT_BITS digits
// ----------------------------------------------------------------------------
// first digit: the first digit beat is offered in the cycle after the fourth word beat
// per scalar: 4 word beats, then NUM_DIGITS digit beats before words are taken
//   again; the shift register yields one digit a cycle unless out_ready is low
// reset: rst_n clears the counts, state, carry and the compare and recode flags;
//   the scalar shift register holds no reset value
module balanced_radix1024_scalar_recoder_core
    import br1024_pkg::*;
#(
    parameter int DIGIT_BITS = DEF_DIGIT_BITS,
    parameter int NUM_DIGITS = DEF_NUM_DIGITS
) (
    input  logic              clk,
    input  logic              rst_n,

    // word beats in
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [WORD_W-1:0] scalar_word,
    input  logic              lane_active,

    // digit beats out
    output logic              out_valid,
    input  logic              out_ready,
    output logic [IDX_W-1:0]  digit_index,
    output logic [MAG_W-1:0]  magnitude,
    output logic              negative,
    output logic              nonzero,
    output logic              scalar_valid,
    output logic              last
);

    localparam int CNT_W     = $clog2(NUM_DIGITS);
    localparam int IDX_EXT_W = (CNT_W > IDX_W) ? CNT_W : IDX_W;
    localparam logic [CNT_W-1:0] LAST_DIGIT = CNT_W'(NUM_DIGITS - 1);

    // controller states
    localparam logic ST_LOAD = 1'b0;
    localparam logic ST_EMIT = 1'b1;

    logic                   state_reg,     state_next;
    logic [WORD_CNT_W-1:0]  word_cnt_reg,  word_cnt_next;
    logic                   below_reg,     below_next;
    logic                   enable_reg,    enable_next;
    logic                   carry_reg,     carry_next;
    logic [CNT_W-1:0]       digit_cnt_reg, digit_cnt_next;
    logic [SCALAR_BITS-1:0] scalar_reg,    scalar_next;

    logic                   in_beat;
    logic                   out_beat;
    logic                   word_lt;
    logic                   word_eq;
    logic                   final_word;
    logic [IDX_EXT_W-1:0]   idx_ext;
    rec_digit_t             cell_digit;

    assign in_beat  = in_valid && in_ready;
    assign out_beat = out_valid && out_ready;

    // lowest digit sits in the bottom bits of the scalar shift register
    br1024_digit_cell #(
        .DIGIT_BITS(DIGIT_BITS)
    ) u_cell (
        .bits     (scalar_reg[DIGIT_BITS-1:0]),
        .carry_in (carry_reg),
        .digit    (cell_digit)
    );

    // running compare against the group order, low word first: a higher word
    // decides, an equal word keeps the verdict of the words below it
    assign word_lt    = scalar_word < GROUP_ORDER[word_cnt_reg];
    assign word_eq    = scalar_word == GROUP_ORDER[word_cnt_reg];
    assign final_word = (word_cnt_reg == WORD_CNT_W'(WORDS_PER_SCALAR - 1));

    always_comb
    begin
        state_next     = state_reg;
        word_cnt_next  = word_cnt_reg;
        below_next     = below_reg;
        enable_next    = enable_reg;
        carry_next     = carry_reg;
        digit_cnt_next = digit_cnt_reg;
        scalar_next    = scalar_reg;

        case (state_reg)
            ST_LOAD:
            begin
                if (in_beat)
                begin
                    // words enter at the top and slide down
                    scalar_next   = {scalar_word, scalar_reg[SCALAR_BITS-1:WORD_W]};
                    below_next    = word_lt
                                    || (word_eq && below_reg && (word_cnt_reg != '0));
                    word_cnt_next = word_cnt_reg + 1'b1;
                    if (final_word)
                    begin
                        enable_next    = lane_active && below_next;
                        carry_next     = 1'b0;
                        digit_cnt_next = '0;
                        word_cnt_next  = '0;
                        state_next     = ST_EMIT;
                    end
                end
            end
            ST_EMIT:
            begin
                if (out_beat)
                begin
                    // bits past the scalar read as zero: zeros fill from the top
                    scalar_next    = scalar_reg >> DIGIT_BITS;
                    carry_next     = cell_digit.carry;
                    digit_cnt_next = digit_cnt_reg + 1'b1;
                    if (digit_cnt_reg == LAST_DIGIT)
                    begin
                        state_next = ST_LOAD;
                    end
                end
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_LOAD;
            word_cnt_reg  <= '0;
            below_reg     <= 1'b0;
            enable_reg    <= 1'b0;
            carry_reg     <= 1'b0;
            digit_cnt_reg <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            word_cnt_reg  <= word_cnt_next;
            below_reg     <= below_next;
            enable_reg    <= enable_next;
            carry_reg     <= carry_next;
            digit_cnt_reg <= digit_cnt_next;
        end
    end

    // scalar data path, no reset
    always_ff @(posedge clk)
    begin
        scalar_reg <= scalar_next;
    end

    // handshake: words only while loading, digits only while emitting
    assign in_ready  = (state_reg == ST_LOAD);
    assign out_valid = (state_reg == ST_EMIT);

    // digit payload straight from the registers; they hold until the beat moves
    assign idx_ext      = IDX_EXT_W'(digit_cnt_reg);
    assign digit_index  = idx_ext[IDX_W-1:0];
    assign magnitude    = enable_reg ? cell_digit.magnitude : '0;
    assign negative     = enable_reg && cell_digit.negative;
    assign nonzero      = enable_reg && cell_digit.nonzero;
    assign scalar_valid = enable_reg;
    assign last         = (digit_cnt_reg == LAST_DIGIT);

    // ------------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------------

    // never load a word and emit a digit in the same cycle
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(in_ready && out_valid))
        else $error("word and digit channels open together");

    // after the last digit beat the block takes words again
    a_last_reopens: assert property (@(posedge clk) disable iff (!rst_n)
        (out_beat && last) |=> (in_ready && !out_valid))
        else $error("block did not return to loading after last digit");

    // digit positions advance by one between beats of a scalar
    a_index_steps: assert property (@(posedge clk) disable iff (!rst_n)
        (out_beat && !last) |=> (digit_index == $past(digit_index) + 1'b1))
        else $error("digit index skipped");

    // a rejected scalar carries only zero digits
    a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !scalar_valid) |-> (magnitude == '0 && !negative && !nonzero))
        else $error("nonzero digit on an invalid scalar");

endmodule
